// ----- hdl/tiir_pkg.sv -----
// ----------------------------------------------------------------------------
// tiir_pkg
// Shared widths, register codes and reset coefficients of the third-order
// direct form I compensator.
// ----------------------------------------------------------------------------
package tiir_pkg;

    // default configuration of the filter
    localparam int DEF_FILTER_ORDER   = 3;
    localparam int DEF_COEF_FRAC_BITS = 24;

    // fixed field widths
    localparam int ERR_W   = 16;
    localparam int COEF_W  = 32;
    localparam int OUT_W   = 32;
    localparam int MAX_ORDER = 3;
    localparam int CFG_IDX_W = 3;

    // product and accumulator widths (seven terms need three guard bits)
    localparam int PROD_E_W = COEF_W + ERR_W;
    localparam int PROD_Y_W = COEF_W + OUT_W;
    localparam int ACC_W    = PROD_Y_W + 3;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COEF_0 = 3'd0,
        REG_NUM_COEF_1 = 3'd1,
        REG_NUM_COEF_2 = 3'd2,
        REG_NUM_COEF_3 = 3'd3,
        REG_DEN_COEF_1 = 3'd4,
        REG_DEN_COEF_2 = 3'd5,
        REG_DEN_COEF_3 = 3'd6
    } cfg_reg_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    // reset coefficients, signed Q8.24
    localparam coef_t NUM_COEF_RST [MAX_ORDER+1] = '{
        32'sd0,
        32'sd764926965,
        -32'sd1518973905,
        32'sd754050295
    };

    // entry i holds the weight of the output i+1 ticks old
    localparam coef_t DEN_COEF_RST [MAX_ORDER] = '{
        -32'sd33549399,
        32'sd16773861,
        32'sd0
    };

endpackage

// ----- hdl/third_order_iir_compensator_top.sv -----
// ----------------------------------------------------------------------------
// third_order_iir_compensator_top
// Direct form I loop compensator: weighted sum of the current and past error
// samples minus weighted past outputs, shifted to integer and saturated.
// ----------------------------------------------------------------------------
// Path: input register, then result register once the result stage is free.
// Throughput: one item per cycle unless stalled; the multiply-add from the
//   input register through saturation back into the output history sets it.
// Reset: histories clear to zero, coefficients load their default values,
//   no item is held.
// ----------------------------------------------------------------------------
module third_order_iir_compensator_top
    import tiir_pkg::*;
#(
    parameter int FILTER_ORDER   = DEF_FILTER_ORDER,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ERR_W-1:0] error_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] drive_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]       cfg_data
);

    localparam int SH_W = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // coefficient registers
    coef_t num_coef_reg [MAX_ORDER+1];
    coef_t den_coef_reg [MAX_ORDER];

    // input stage and result stage
    logic                    in_valid_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] drive_reg;

    // histories, entry 0 is the newest
    logic signed [ERR_W-1:0] err_hist_reg [FILTER_ORDER];
    logic signed [OUT_W-1:0] out_hist_reg [FILTER_ORDER];

    logic                    advance;
    logic signed [PROD_E_W-1:0] prod_cur;
    logic signed [PROD_E_W-1:0] prod_e [FILTER_ORDER];
    logic signed [PROD_Y_W-1:0] prod_y [FILTER_ORDER];
    logic signed [ACC_W-1:0]    acc;
    logic signed [SH_W-1:0]     acc_sh;
    logic [SH_W-OUT_W:0]        acc_upper;
    logic signed [OUT_W-1:0]    drive_next;

    // handshake: the input stage moves on whenever the result stage is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign drive_value = drive_reg;
    assign cfg_ready = 1'b1;

    // products, all in parallel
    always_comb
    begin
        prod_cur = num_coef_reg[0] * err_reg;
        for (int i = 0; i < FILTER_ORDER; i++)
        begin
            prod_e[i] = num_coef_reg[i+1] * err_hist_reg[i];
            prod_y[i] = den_coef_reg[i] * out_hist_reg[i];
        end
    end

    // full-width sum
    always_comb
    begin
        acc = ACC_W'(prod_cur);
        for (int i = 0; i < FILTER_ORDER; i++)
        begin
            acc = acc + ACC_W'(prod_e[i]) - ACC_W'(prod_y[i]);
        end
    end

    // drop fraction bits (floor) and saturate to the output range
    always_comb
    begin
        acc_sh    = acc[ACC_W-1:COEF_FRAC_BITS];
        acc_upper = acc_sh[SH_W-1:OUT_W-1];
        if ((&acc_upper) || !(|acc_upper))
        begin
            drive_next = acc_sh[OUT_W-1:0];
        end
        else if (acc_sh[SH_W-1])
        begin
            drive_next = SAT_MIN;
        end
        else
        begin
            drive_next = SAT_MAX;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            err_reg <= error_sample;
        end
        if (advance)
        begin
            drive_reg <= drive_next;
        end
    end

    // history shift lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                err_hist_reg[i] <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = FILTER_ORDER - 1; i > 0; i--)
            begin
                err_hist_reg[i] <= err_hist_reg[i-1];
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
            err_hist_reg[0] <= err_reg;
            out_hist_reg[0] <= drive_next;
        end
    end

    // coefficient writes, unknown codes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coef_reg <= NUM_COEF_RST;
            den_coef_reg <= DEN_COEF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_COEF_0: num_coef_reg[0] <= cfg_data;
                REG_NUM_COEF_1: num_coef_reg[1] <= cfg_data;
                REG_NUM_COEF_2: num_coef_reg[2] <= cfg_data;
                REG_NUM_COEF_3: num_coef_reg[3] <= cfg_data;
                REG_DEN_COEF_1: den_coef_reg[0] <= cfg_data;
                REG_DEN_COEF_2: den_coef_reg[1] <= cfg_data;
                REG_DEN_COEF_3: den_coef_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/tiir_checker.sv -----
// ----------------------------------------------------------------------------
// tiir_checker
// Port-level checks of the compensator's flow control and result timing.
// ----------------------------------------------------------------------------
module tiir_checker
    import tiir_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] drive_value,
    input logic                    cfg_valid,
    input logic                    cfg_ready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_value))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // each accepted item is followed by a valid result
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("accepted item produced no result");

    // configuration is never blocked
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind third_order_iir_compensator_top tiir_checker u_tiir_checker (.*);
